// ===== rtl/kst_pkg.sv =====
// shared types, codes and constants of the keyframe servo trajectory unit
`timescale 1ns / 1ps
package kst_pkg;

	localparam int MAX_KEYFRAMES_DEF = 16;
	localparam int CENTRE_Q88 = 23040;
	localparam int FULL_Q88 = 46080;
	localparam int PROD_W = 42;
	localparam int CNT_W = 5;

	localparam logic [2:0] MODE_LOAD = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_STOP = 3'd2;
	localparam logic [2:0] MODE_PAUSE = 3'd3;
	localparam logic [2:0] MODE_RESUME = 3'd4;
	localparam logic [2:0] MODE_TICK = 3'd5;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ANGLE = 2'd1;
	localparam logic [1:0] KIND_FINISHED = 2'd2;

	typedef struct packed {
		logic [2:0]         mode;
		logic [31:0]        now_ms;
		logic [3:0]         key_slot;
		logic [23:0]        key_time_ms;
		logic signed [15:0] key_angle;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] servo_angle;
		logic        running;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic accept;
		logic rd_p;
		logic rd_c;
		logic eval;
		logic advance;
		logic mul;
		logic div_init;
		logic div_step;
		logic done_angle;
		logic done_finish;
	} cmd_t;

	typedef struct packed {
		logic tick_run;
		logic more;
		logic seg_ok;
		logic div_last;
	} status_t;

endpackage

// ===== rtl/kst_ctrl.sv =====
// sequencer for tick processing: segment walk, multiply and divide steps
`timescale 1ns / 1ps
module kst_ctrl import kst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_block,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_CHK, S_RDC, S_EVAL, S_MUL, S_DINIT, S_DIV, S_OUT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.accept = in_valid && !out_block;
			S_CHK: begin
				cmd.rd_p = status.more;
				cmd.done_finish = !status.more;
			end
			S_RDC: cmd.rd_c = 1'b1;
			S_EVAL: begin
				cmd.eval = status.seg_ok;
				cmd.advance = !status.seg_ok;
			end
			S_MUL: cmd.mul = 1'b1;
			S_DINIT: cmd.div_init = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_OUT: cmd.done_angle = 1'b1;
			default: cmd.busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.accept && status.tick_run) state_q <= S_CHK;
				S_CHK: state_q <= status.more ? S_RDC : S_IDLE;
				S_RDC: state_q <= S_EVAL;
				S_EVAL: state_q <= status.seg_ok ? S_MUL : S_CHK;
				S_MUL: state_q <= S_DINIT;
				S_DINIT: state_q <= S_DIV;
				S_DIV: if (status.div_last) state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/kst_dpath.sv =====
// keyframe memory, animation clock, multiply, serial divider and result register
`timescale 1ns / 1ps
module kst_dpath import kst_pkg::*; #(
	parameter int MAX_KEYFRAMES = MAX_KEYFRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          status,
	input  in_item_t         in_data,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	localparam int AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
	localparam int DCW = $clog2(PROD_W);

	logic [23:0] tmem [MAX_KEYFRAMES];
	logic [15:0] amem [MAX_KEYFRAMES];
	logic [23:0] rd_time_q;
	logic signed [15:0] rd_angle_q;

	logic [CNT_W-1:0] kc_q, seg_q, count;
	logic active_q, paused_q;
	logic [31:0] start_q, accum_q, t_q;

	logic [23:0] tp_q;
	logic signed [15:0] ap_q;
	logic signed [16:0] da_q;
	logic signed [24:0] dt_q, d_q;
	logic signed [PROD_W-1:0] prod_q;
	logic neg_q;
	logic [PROD_W-1:0] nq_q;
	logic [24:0] rem_q;
	logic [DCW-1:0] dcnt_q;

	logic [AW-1:0] raddr;
	logic signed [24:0] d_now;
	logic [25:0] r2;
	logic r_ge;
	logic signed [PROD_W+1:0] q_s, pos_s, o_s;
	logic [15:0] sat;
	logic tick_item;
	logic [31:0] t_now;
	logic res_load;

	assign count = (32'(kc_q) > MAX_KEYFRAMES) ? CNT_W'(MAX_KEYFRAMES) : kc_q;
	assign tick_item = (in_data.mode == MODE_TICK) && active_q && !paused_q;
	assign t_now = accum_q + in_data.now_ms - start_q;

	assign status.tick_run = tick_item;
	assign status.more = seg_q < count;
	assign d_now = $signed({1'b0, rd_time_q}) - $signed({1'b0, tp_q});
	assign status.seg_ok = (d_now > 0) && (t_q < {8'd0, rd_time_q});
	assign status.div_last = (dcnt_q == DCW'(PROD_W - 1));

	assign raddr = cmd.rd_p ? AW'(seg_q - CNT_W'(1)) : AW'(seg_q);

	// a new result item is loaded into the output register
	assign res_load = (cmd.accept && !tick_item) || cmd.done_finish || cmd.done_angle;

	// keyframe table, registered read
	always_ff @(posedge clk) begin
		if (cmd.accept && in_data.mode == MODE_LOAD && 32'(in_data.key_slot) < MAX_KEYFRAMES) begin
			tmem[AW'(in_data.key_slot)] <= in_data.key_time_ms;
			amem[AW'(in_data.key_slot)] <= in_data.key_angle;
		end
		if (cmd.rd_p || cmd.rd_c) begin
			rd_time_q <= tmem[raddr];
			rd_angle_q <= amem[raddr];
		end
	end

	// one restoring division step on magnitudes
	assign r2 = {rem_q, nq_q[PROD_W-1]};
	assign r_ge = r2 >= {1'b0, d_q};

	always_comb begin
		q_s = $signed({2'b00, nq_q});
		if (neg_q) q_s = -q_s - ((rem_q != '0) ? 44'sd1 : 44'sd0);
		pos_s = q_s + 44'(ap_q);
		o_s = pos_s + 44'sd23040;
		if (o_s < 0) sat = 16'd0;
		else if (o_s > 44'sd46080) sat = 16'(FULL_Q88);
		else sat = o_s[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) t_q <= t_now;
		if (cmd.rd_c) begin
			tp_q <= rd_time_q;
			ap_q <= rd_angle_q;
		end
		if (cmd.eval) begin
			da_q <= 17'(rd_angle_q) - 17'(ap_q);
			dt_q <= $signed({1'b0, t_q[23:0]}) - $signed({1'b0, tp_q});
			d_q <= d_now;
		end
		if (cmd.mul) prod_q <= PROD_W'(da_q) * PROD_W'(dt_q);
		if (cmd.div_init) begin
			neg_q <= prod_q[PROD_W-1];
			nq_q <= prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
			rem_q <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= r_ge ? 25'(r2 - {1'b0, d_q}) : r2[24:0];
			nq_q <= {nq_q[PROD_W-2:0], r_ge};
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q <= '0;
			seg_q <= CNT_W'(1);
			active_q <= 1'b0;
			paused_q <= 1'b0;
			start_q <= '0;
			accum_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (res_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_we) begin
				kc_q <= cfg_data;
				seg_q <= CNT_W'(1);
			end
			if (cmd.advance) seg_q <= seg_q + CNT_W'(1);
			if (cmd.accept) begin
				case (in_data.mode)
					MODE_START: if (!active_q) begin
						paused_q <= 1'b0;
						start_q <= in_data.now_ms;
						accum_q <= '0;
						seg_q <= CNT_W'(1);
						active_q <= 1'b1;
					end
					MODE_STOP: active_q <= 1'b0;
					MODE_PAUSE: if (active_q && !paused_q) begin
						paused_q <= 1'b1;
						accum_q <= t_now;
					end
					MODE_RESUME: if (active_q && paused_q) begin
						start_q <= in_data.now_ms;
						paused_q <= 1'b0;
					end
					default: ;
				endcase
				if (!tick_item) begin
					out_data.kind <= KIND_NONE;
					out_data.servo_angle <= '0;
					case (in_data.mode) inside
						// start is ignored while active, so a paused run stays paused
						MODE_START: out_data.running <= !active_q || !paused_q;
						MODE_STOP, MODE_PAUSE: out_data.running <= 1'b0;
						MODE_RESUME: out_data.running <= active_q;
						default: out_data.running <= active_q && !paused_q;
					endcase
				end
			end
			if (cmd.done_finish) begin
				active_q <= 1'b0;
				out_data.kind <= KIND_FINISHED;
				out_data.servo_angle <= '0;
				out_data.running <= 1'b0;
			end
			if (cmd.done_angle) begin
				out_data.kind <= KIND_ANGLE;
				out_data.servo_angle <= sat;
				out_data.running <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/keyframe_servo_trajectory_unit.sv =====
// top level of the keyframe servo trajectory unit
// non-tick items, idle ticks: result in the cycle after acceptance, one item in work at a time
// a running tick checks each keyframe segment in turn (check, read, evaluate), then runs the
// multiply and the 42-step serial divider when a segment holds, or finishes when none is left
// arst_n clears the clock state, keyframe count and segment index (to 1)
// the keyframe table is not cleared and holds garbage until loaded
`timescale 1ns / 1ps
module keyframe_servo_trajectory_unit import kst_pkg::*; #(
	parameter int MAX_KEYFRAMES = MAX_KEYFRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	cmd_t cmd;
	status_t status;
	logic out_block;

	assign out_block = out_valid && out_stall;
	assign in_stall = cmd.busy || out_block;
	assign cfg_ready = 1'b1;

	kst_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.out_block(out_block),
		.status(status),
		.cmd(cmd)
	);

	kst_dpath #(.MAX_KEYFRAMES(MAX_KEYFRAMES)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.in_data(in_data),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

// ===== dv/kst_checker.sv =====
// checker: watches the channels of the trajectory unit, predicts each result and compares
`timescale 1ns / 1ps
module kst_checker import kst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_item_t        out_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	logic [23:0]        key_time_tbl [16];
	logic signed [15:0] key_angle_tbl [16];
	int                 seg_idx;
	int                 frame_count;
	logic               is_active;
	logic               is_paused;
	logic [31:0]        start_ms;
	logic [31:0]        acc_ms;
	out_item_t          servo_expected [$];

	function automatic out_item_t predict_servo(in_item_t it);
		out_item_t r;
		int cnt;
		logic [31:0] elapsed;
		longint t, tp, tc, d, ap, ac, num, q, o;
		bit done;
		r = '0;
		r.kind = KIND_NONE;
		case (it.mode)
			MODE_LOAD: begin
				key_time_tbl[it.key_slot] = it.key_time_ms;
				key_angle_tbl[it.key_slot] = it.key_angle;
			end
			MODE_START: begin
				if (!is_active) begin
					is_paused = 1'b0;
					start_ms = it.now_ms;
					acc_ms = '0;
					seg_idx = 1;
					is_active = 1'b1;
				end
			end
			MODE_STOP: is_active = 1'b0;
			MODE_PAUSE: begin
				if (is_active && !is_paused) begin
					is_paused = 1'b1;
					acc_ms = acc_ms + it.now_ms - start_ms;
				end
			end
			MODE_RESUME: begin
				if (is_active && is_paused) begin
					start_ms = it.now_ms;
					is_paused = 1'b0;
				end
			end
			MODE_TICK: begin
				if (is_active && !is_paused) begin
					cnt = (frame_count > 16) ? 16 : frame_count;
					elapsed = acc_ms + it.now_ms - start_ms;
					t = longint'(elapsed);
					r.kind = KIND_FINISHED;
					done = 1'b0;
					while (!done && seg_idx < cnt) begin
						tp = longint'(key_time_tbl[seg_idx-1]);
						tc = longint'(key_time_tbl[seg_idx]);
						d = tc - tp;
						if (d > 0 && t < tc) begin
							ap = longint'(key_angle_tbl[seg_idx-1]);
							ac = longint'(key_angle_tbl[seg_idx]);
							num = (ac - ap) * (t - tp);
							q = num / d;
							// round toward minus infinity
							if ((num % d) != 0 && num < 0)
								q = q - 1;
							o = ap + q + CENTRE_Q88;
							if (o < 0)
								o = 0;
							if (o > FULL_Q88)
								o = FULL_Q88;
							r.servo_angle = 16'(o);
							r.kind = KIND_ANGLE;
							done = 1'b1;
						end else begin
							seg_idx++;
						end
					end
					if (r.kind == KIND_FINISHED)
						is_active = 1'b0;
				end
			end
			default: ;
		endcase
		r.running = is_active && !is_paused;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			seg_idx = 1;
			frame_count = 0;
			is_active = 1'b0;
			is_paused = 1'b0;
			start_ms = '0;
			acc_ms = '0;
			servo_expected.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (servo_expected.size() == 0) begin
					$display("%0t: unexpected result item %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = servo_expected.pop_front();
					if (out_data.kind !== want.kind || out_data.servo_angle !== want.servo_angle ||
							out_data.running !== want.running) begin
						$display("%0t: mismatch expected kind %0d angle %0d running %0d, actual kind %0d angle %0d running %0d",
							$time, want.kind, want.servo_angle, want.running,
							out_data.kind, out_data.servo_angle, out_data.running);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				frame_count = int'(cfg_data);
				seg_idx = 1;
			end
			if (in_valid && !in_stall)
				servo_expected.push_back(predict_servo(in_data));
			pending <= servo_expected.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: drives keyframe loads, clock commands and ticks into the trajectory unit
`timescale 1ns / 1ps
module tb_top import kst_pkg::*; ();

	localparam int STALL_LIMIT = 4000;
	localparam int ITEM_TARGET = 1350;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;
	int               fail_count;
	int               pending;
	int               in_pct;
	int               out_pct;
	int               item_cnt;
	int               seq_cnt;
	int               quiet_cycles;
	logic [31:0]      now_ms;

	keyframe_servo_trajectory_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	kst_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < out_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic send_item(logic [2:0] mode, logic [31:0] now, logic [3:0] slot,
			logic [23:0] ktime, int kangle);
		in_valid = 1'b0;
		while ($urandom_range(0, 99) < in_pct) @(negedge clk);
		in_valid = 1'b1;
		in_data.mode = mode;
		in_data.now_ms = now;
		in_data.key_slot = slot;
		in_data.key_time_ms = ktime;
		in_data.key_angle = 16'(kangle);
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		item_cnt++;
	endtask

	// write the count only once the unit has drained
	task automatic write_count(int v);
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = CNT_W'(v);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int rand_angle();
		return int'($urandom_range(0, 46080)) - 23040;
	endfunction

	task automatic tick(int step);
		now_ms = now_ms + step;
		send_item(MODE_TICK, now_ms, '0, '0, 0);
	endtask

	// one animation: count, mostly rising keyframes, start, then ticks mixed with clock commands, loads and unused modes
	task automatic run_sequence();
		int cnt, sel, n;
		logic [23:0] kt;
		sel = $urandom_range(0, 9);
		cnt = (sel == 0) ? 16 : (sel == 1) ? $urandom_range(17, 31) :
			(sel == 2) ? $urandom_range(0, 1) : $urandom_range(2, 8);
		write_count(cnt);
		kt = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(0, 16770000)) :
			24'($urandom_range(0, 60));
		for (int s = 0; s < ((cnt > 16) ? 16 : cnt); s++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				kt = kt - 24'($urandom_range(0, 40));
			else if (sel > 1)
				kt = kt + 24'($urandom_range(1, 200));
			send_item(MODE_LOAD, $urandom, 4'(s), kt, rand_angle());
		end
		now_ms = $urandom;
		send_item(MODE_START, now_ms, 4'($urandom), 24'($urandom), rand_angle());
		n = $urandom_range(10, 40);
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				tick($urandom_range(0, 60));
			end else if (sel < 83) begin
				now_ms = now_ms + $urandom_range(0, 50);
				send_item(MODE_PAUSE, now_ms, 4'($urandom), 24'($urandom), rand_angle());
				tick($urandom_range(0, 30));
				now_ms = now_ms + $urandom_range(0, 500);
				send_item(MODE_RESUME, now_ms, 4'($urandom), 24'($urandom), rand_angle());
			end else if (sel < 88) begin
				send_item(3'($urandom_range(6, 7)), $urandom, 4'($urandom), 24'($urandom),
					rand_angle());
			end else if (sel < 92) begin
				send_item(MODE_START, $urandom, 4'($urandom), 24'($urandom), rand_angle());
			end else if (sel < 94) begin
				send_item(MODE_STOP, now_ms, 4'($urandom), 24'($urandom), rand_angle());
			end else if (sel < 97) begin
				send_item(MODE_LOAD, $urandom, 4'($urandom), 24'($urandom), rand_angle());
			end else begin
				tick($urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_pct = 11;
		out_pct = 51;
		item_cnt = 0;
		seq_cnt = 0;
		now_ms = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the whole table so no unwritten slot is ever read
		for (int s = 0; s < 16; s++)
			send_item(MODE_LOAD, 32'hFFFF_FFFF, 4'(s), 24'(s * 100), (s % 2) ? 23040 : -23040);
		// tick while idle, wrong-state clock commands, unused modes
		send_item(MODE_TICK, 32'd5, '0, '0, 0);
		send_item(MODE_PAUSE, 32'd5, '0, '0, 0);
		send_item(MODE_RESUME, 32'd5, '0, '0, 0);
		send_item(MODE_STOP, 32'd5, '0, '0, 0);
		send_item(3'd6, '0, '0, '0, 0);
		send_item(3'd7, 32'hFFFF_FFFF, 4'hF, 24'hFF_FFFF, -1);
		// too few keyframes finishes at once
		write_count(1);
		send_item(MODE_START, 32'hFFFF_FFF0, '0, '0, 0);
		send_item(MODE_TICK, 32'h0000_0010, '0, '0, 0);
		// zero-length, falling and extreme segments, oversized count, wrap of now
		write_count(31);
		send_item(MODE_LOAD, '0, 4'd1, 24'd0, 23040);
		send_item(MODE_LOAD, '0, 4'd2, 24'hFF_FFFF, -23040);
		send_item(MODE_LOAD, '0, 4'd3, 24'd50, 0);
		send_item(MODE_START, 32'hFFFF_FFFE, '0, '0, 0);
		send_item(MODE_START, 32'd3, '0, '0, 0);
		send_item(MODE_TICK, 32'd100, '0, '0, 0);
		send_item(MODE_PAUSE, 32'd200, '0, '0, 0);
		send_item(MODE_TICK, 32'd300, '0, '0, 0);
		send_item(MODE_RESUME, 32'd400, '0, '0, 0);
		send_item(MODE_TICK, 32'h00FF_FFFF, '0, '0, 0);

		while (item_cnt < ITEM_TARGET) begin
			if (item_cnt >= 900) begin
				in_pct = 0;
				out_pct = 0;
			end else if (item_cnt >= 450) begin
				in_pct = 51;
				out_pct = 11;
			end
			run_sequence();
			seq_cnt++;
		end

		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		$display("%0d items in %0d animations: loads, clock commands, ticks, counts 0..31",
			item_cnt, seq_cnt);
		$display("idling on both sides in three phases, %0d failures", fail_count);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/kst_pkg.sv
rtl/kst_ctrl.sv
rtl/kst_dpath.sv
rtl/keyframe_servo_trajectory_unit.sv
dv/kst_checker.sv
dv/tb_top.sv
